// ===== sv/cgs_pkg.sv =====
`timescale 1ns / 1ps

package cgs_pkg;

    localparam int MAX_COLUMNS     = 4096;
    localparam int MAX_ROWS        = 1024;
    localparam int MAX_HALF_WINDOW = 1023;

    localparam int COL_AW     = 12;
    localparam int COL_W      = 13;
    localparam int CNT_W      = 11;
    localparam int ROW_W      = 10;
    localparam int HW_W       = 10;
    localparam int BIN_W      = 13;
    localparam int HIST_AW    = 11;
    localparam int HIST_DEPTH = MAX_ROWS + 1;
    localparam int SUM_W      = 22;
    localparam int REM_W      = 24;
    localparam int DEN_W      = 12;
    localparam int J_W        = 15;
    localparam int K_W        = 4;

    localparam int IN_W  = 24;
    localparam int OUT_W = 56;
    localparam int AW    = 4;
    localparam int DW    = 32;

    localparam logic [2:0] REQ_LOAD  = 3'd0;
    localparam logic [2:0] REQ_FIN   = 3'd1;
    localparam logic [2:0] REQ_RDCOL = 3'd2;
    localparam logic [2:0] REQ_RDBIN = 3'd3;
    localparam logic [2:0] REQ_CLEAR = 3'd4;

    localparam logic [1:0] REG_DATA_TYPE = 2'd0;
    localparam logic [1:0] REG_NUM_ROWS  = 2'd1;
    localparam logic [1:0] REG_NUM_COLS  = 2'd2;
    localparam logic [1:0] REG_HALF_WIN  = 2'd3;

    localparam logic [7:0] GAP_CHAR = 8'h2D;
    localparam logic [7:0] INDET_AA = 8'h58;
    localparam logic [7:0] INDET_NT = 8'h4E;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_REJECT = 2'd2,
        ST_RANGE  = 2'd3
    } t_status;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_CAPTURE,
        OP_LOAD,
        OP_HINC,
        OP_RD,
        OP_CLR,
        OP_HCLR,
        OP_FIN_INIT,
        OP_SUM_RD,
        OP_SUM_ACC,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_WIN_WR,
        OP_ADD_RD,
        OP_ADD_ACC,
        OP_SUB_RD,
        OP_SUB_ACC,
        OP_RESULT
    } t_op;

    typedef struct packed {
        t_op     op;
        t_status status;
    } t_dp_cmd;

    typedef struct packed {
        logic [2:0] req;
        logic       load_full;
        logic       col_close;
        logic       fin_ok;
        logic       rng_bad;
        logic       hclr_last;
        logic       sum_last;
        logic       div_last;
        logic       win_last;
        logic       out_space;
    } t_dp_stat;

endpackage

// ===== sv/column_gap_statistics.sv =====
`timescale 1ns / 1ps
// column gap statistics over an alignment streamed one residue at a time
// input stream (i_s_*): one request per transaction: load residue, finalize
//   window, read column, read histogram bin or clear
// output stream (o_m_*): exactly one result transaction per request, in order
// apb port: data_type at 0x0, num_rows at 0x4, num_columns at 0x8,
//   half_window at 0xc; write only while no request is in flight
// finalize: a histogram clearing sweep, the first window sum, then per column
//   a restoring divider and the sliding sum through the single read port of
//   the raw store
// one request is worked at a time; the next is taken as soon as the result
//   sits in the output register, even while the receiver stalls
// reset: a histogram clearing sweep runs before the first request is
//   accepted; configuration writes are taken during it
// a stalled receiver holds the result register, and a following result waits
//   in the controller until the register frees up
module column_gap_statistics (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_s_tvalid,
    output logic                      o_s_tready,
    // req_type [2:0], residue [10:3], index [22:11]
    input  logic [cgs_pkg::IN_W-1:0]  i_s_tdata,
    output logic                      o_m_tvalid,
    input  logic                      i_m_tready,
    // status [1:0], gap_count [12:2], indet_count [23:13], bin_count [36:24],
    // max_gaps [47:37], load_complete [48]
    output logic [cgs_pkg::OUT_W-1:0] o_m_tdata,
    input  logic                      i_psel,
    input  logic                      i_penable,
    input  logic                      i_pwrite,
    input  logic [cgs_pkg::AW-1:0]    i_paddr,
    input  logic [cgs_pkg::DW-1:0]    i_pwdata,
    output logic [cgs_pkg::DW-1:0]    o_prdata,
    output logic                      o_pready
);
    import cgs_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    assign o_pready = 1'b1;

    cgs_controller u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_tvalid),
        .o_in_ready (o_s_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    cgs_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_in_data   (i_s_tdata),
        .i_psel      (i_psel),
        .i_penable   (i_penable),
        .i_pwrite    (i_pwrite),
        .i_paddr     (i_paddr),
        .i_pwdata    (i_pwdata),
        .o_prdata    (o_prdata),
        .o_out_valid (o_m_tvalid),
        .o_out_data  (o_m_tdata),
        .i_out_ready (i_m_tready)
    );

endmodule

// ===== sv/cgs_datapath.sv =====
`timescale 1ns / 1ps

module cgs_datapath (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  cgs_pkg::t_dp_cmd          i_cmd,
    output cgs_pkg::t_dp_stat         o_stat,
    input  logic [cgs_pkg::IN_W-1:0]  i_in_data,
    input  logic                      i_psel,
    input  logic                      i_penable,
    input  logic                      i_pwrite,
    input  logic [cgs_pkg::AW-1:0]    i_paddr,
    input  logic [cgs_pkg::DW-1:0]    i_pwdata,
    output logic [cgs_pkg::DW-1:0]    o_prdata,
    output logic                      o_out_valid,
    output logic [cgs_pkg::OUT_W-1:0] o_out_data,
    input  logic                      i_out_ready
);
    import cgs_pkg::*;

    function automatic logic [COL_AW-1:0] mirror(input logic signed [J_W-1:0] j,
                                                input logic [COL_W-1:0] n);
        logic signed [J_W-1:0] k;
        logic signed [J_W-1:0] ns;
        ns = $signed({2'b00, n});
        if (j < 0) begin
            k = -j;
        end else if (j >= ns) begin
            k = (ns <<< 1) - j - 15'sd2;
        end else begin
            k = j;
        end
        if (k < 0) begin
            k = '0;
        end
        if (k >= ns) begin
            k = ns - 15'sd1;
        end
        return k[COL_AW-1:0];
    endfunction

    function automatic logic [HIST_AW-1:0] clamp_bin(input logic [CNT_W-1:0] g);
        if (g > CNT_W'(MAX_ROWS)) begin
            return HIST_AW'(MAX_ROWS);
        end
        return g;
    endfunction

    // configuration
    logic               r_data_type;
    logic [CNT_W-1:0]   r_num_rows;
    logic [COL_W-1:0]   r_num_cols;
    logic [HW_W-1:0]    r_half;
    logic [CNT_W-1:0]   eff_rows;
    logic [COL_W-1:0]   eff_cols;

    // item and state
    logic [2:0]         r_req;
    logic [7:0]         r_res;
    logic [COL_AW-1:0]  r_idx;
    logic [ROW_W-1:0]   r_row;
    logic [COL_W-1:0]   r_col;
    logic [CNT_W-1:0]   r_run_g;
    logic [CNT_W-1:0]   r_run_i;
    logic [CNT_W-1:0]   r_max;
    logic [HIST_AW-1:0] r_hidx;
    logic [HIST_AW-1:0] r_g;

    // finalize
    logic signed [J_W-1:0] r_j;
    logic [COL_AW-1:0]  r_i;
    logic [SUM_W-1:0]   r_sum;
    logic [REM_W-1:0]   r_rem;
    logic [DEN_W-1:0]   r_den;
    logic [CNT_W-1:0]   r_q;
    logic [K_W-1:0]     r_k;

    // memories
    logic [CNT_W-1:0]   m_raw  [MAX_COLUMNS];
    logic [CNT_W-1:0]   m_win  [MAX_COLUMNS];
    logic [CNT_W-1:0]   m_ind  [MAX_COLUMNS];
    logic [BIN_W-1:0]   m_hist [HIST_DEPTH];
    logic [CNT_W-1:0]   r_raw_q;
    logic [CNT_W-1:0]   r_win_q;
    logic [CNT_W-1:0]   r_ind_q;
    logic [BIN_W-1:0]   r_hist_q;

    logic               r_out_valid;
    logic [OUT_W-1:0]   r_out_data;

    logic               cfg_wr;
    logic [7:0]         indet_char;
    logic               is_gap;
    logic               is_ind;
    logic [CNT_W-1:0]   n_gap;
    logic [CNT_W-1:0]   n_ind;
    logic               close;
    logic signed [J_W-1:0] j_sel;
    logic [COL_AW-1:0]  raw_addr;
    logic [REM_W-1:0]   dsh;
    logic               hist_we;
    logic [HIST_AW-1:0] hist_wa;
    logic [BIN_W-1:0]   hist_wd;
    logic               hist_re;
    logic [HIST_AW-1:0] hist_ra;
    logic               out_space;
    logic [CNT_W-1:0]   res_gap;
    logic [CNT_W-1:0]   res_ind;
    logic [BIN_W-1:0]   res_bin;
    logic               rd_ok;

    assign cfg_wr = i_psel & i_penable & i_pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data_type <= 1'b1;
            r_num_rows  <= CNT_W'(1);
            r_num_cols  <= COL_W'(1);
            r_half      <= '0;
        end else if (cfg_wr) begin
            case (i_paddr[3:2])
                REG_DATA_TYPE: r_data_type <= i_pwdata[0];
                REG_NUM_ROWS:  r_num_rows  <= i_pwdata[CNT_W-1:0];
                REG_NUM_COLS:  r_num_cols  <= i_pwdata[COL_W-1:0];
                REG_HALF_WIN:  r_half      <= i_pwdata[HW_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (i_paddr[3:2])
            REG_DATA_TYPE: o_prdata = DW'(r_data_type);
            REG_NUM_ROWS:  o_prdata = DW'(r_num_rows);
            REG_NUM_COLS:  o_prdata = DW'(r_num_cols);
            REG_HALF_WIN:  o_prdata = DW'(r_half);
            default:       o_prdata = '0;
        endcase
    end

    always_comb begin
        if (r_num_rows == '0) begin
            eff_rows = CNT_W'(1);
        end else if (r_num_rows > CNT_W'(MAX_ROWS)) begin
            eff_rows = CNT_W'(MAX_ROWS);
        end else begin
            eff_rows = r_num_rows;
        end
        if (r_num_cols == '0) begin
            eff_cols = COL_W'(1);
        end else if (r_num_cols > COL_W'(MAX_COLUMNS)) begin
            eff_cols = COL_W'(MAX_COLUMNS);
        end else begin
            eff_cols = r_num_cols;
        end
    end

    // residue classification
    assign indet_char = r_data_type ? INDET_AA : INDET_NT;
    assign is_gap     = (r_res == GAP_CHAR);
    assign is_ind     = !is_gap && (r_res == indet_char);
    assign n_gap      = r_run_g + CNT_W'(is_gap);
    assign n_ind      = r_run_i + CNT_W'(is_ind);
    assign close      = (CNT_W'(r_row) + CNT_W'(1)) >= eff_rows;

    always_comb begin
        case (i_cmd.op)
            OP_ADD_RD: j_sel = $signed({3'b000, r_i}) + $signed({5'b00000, r_half}) + 15'sd1;
            OP_SUB_RD: j_sel = $signed({3'b000, r_i}) - $signed({5'b00000, r_half});
            default:   j_sel = r_j;
        endcase
    end
    assign raw_addr = mirror(j_sel, eff_cols);
    assign dsh      = REM_W'(r_den) << r_k;

    always_comb begin
        hist_we = 1'b0;
        hist_wa = r_hidx;
        hist_wd = '0;
        if (i_cmd.op == OP_HCLR) begin
            hist_we = 1'b1;
        end else if (i_cmd.op == OP_HINC) begin
            hist_we = 1'b1;
            hist_wa = r_g;
            hist_wd = r_hist_q + BIN_W'(1);
        end
        hist_re = 1'b0;
        hist_ra = r_idx[HIST_AW-1:0];
        case (i_cmd.op)
            OP_LOAD: begin
                hist_re = close;
                hist_ra = clamp_bin(n_gap);
            end
            OP_WIN_WR: begin
                hist_re = 1'b1;
                hist_ra = clamp_bin(r_q);
            end
            OP_RD: begin
                hist_re = (r_req == REQ_RDBIN);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (hist_we) begin
            m_hist[hist_wa] <= hist_wd;
        end
        if (hist_re) begin
            r_hist_q <= m_hist[hist_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_LOAD && close) begin
            m_raw[r_col[COL_AW-1:0]] <= n_gap;
            m_ind[r_col[COL_AW-1:0]] <= n_ind;
        end
        if (i_cmd.op == OP_SUM_RD || i_cmd.op == OP_ADD_RD || i_cmd.op == OP_SUB_RD) begin
            r_raw_q <= m_raw[raw_addr];
        end
        if (i_cmd.op == OP_RD && r_req == REQ_RDCOL) begin
            r_ind_q <= m_ind[r_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_LOAD && close) begin
            m_win[r_col[COL_AW-1:0]] <= n_gap;
        end else if (i_cmd.op == OP_WIN_WR) begin
            m_win[r_i] <= r_q;
        end
        if (i_cmd.op == OP_RD && r_req == REQ_RDCOL) begin
            r_win_q <= m_win[r_idx];
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row   <= '0;
            r_col   <= '0;
            r_run_g <= '0;
            r_run_i <= '0;
            r_max   <= '0;
            r_hidx  <= '0;
        end else begin
            case (i_cmd.op)
                OP_LOAD: begin
                    if (close) begin
                        r_col   <= r_col + COL_W'(1);
                        r_row   <= '0;
                        r_run_g <= '0;
                        r_run_i <= '0;
                    end else begin
                        r_row   <= r_row + ROW_W'(1);
                        r_run_g <= n_gap;
                        r_run_i <= n_ind;
                    end
                end
                OP_HINC: begin
                    if (CNT_W'(r_g) > r_max) begin
                        r_max <= CNT_W'(r_g);
                    end
                end
                OP_CLR: begin
                    r_row   <= '0;
                    r_col   <= '0;
                    r_run_g <= '0;
                    r_run_i <= '0;
                    r_max   <= '0;
                end
                OP_FIN_INIT: begin
                    r_max <= '0;
                end
                OP_HCLR: begin
                    if (r_hidx == HIST_AW'(HIST_DEPTH - 1)) begin
                        r_hidx <= '0;
                    end else begin
                        r_hidx <= r_hidx + HIST_AW'(1);
                    end
                end
                default: ;
            endcase
        end
    end

    // item capture, window sum and divider
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_CAPTURE: begin
                r_req <= i_in_data[2:0];
                r_res <= i_in_data[10:3];
                r_idx <= i_in_data[22:11];
            end
            OP_LOAD: begin
                r_g <= clamp_bin(n_gap);
            end
            OP_FIN_INIT: begin
                r_sum <= '0;
                r_j   <= -$signed({5'b00000, r_half});
                r_i   <= '0;
            end
            OP_SUM_ACC: begin
                r_sum <= r_sum + SUM_W'(r_raw_q);
                r_j   <= r_j + 15'sd1;
            end
            OP_ADD_ACC: begin
                r_sum <= r_sum + SUM_W'(r_raw_q);
            end
            OP_SUB_ACC: begin
                r_sum <= r_sum - SUM_W'(r_raw_q);
                r_i   <= r_i + COL_AW'(1);
            end
            OP_DIV_INIT: begin
                r_rem <= {1'b0, r_sum, 1'b0} + REM_W'({r_half, 1'b1});
                r_den <= {r_half, 2'b10};
                r_q   <= '0;
                r_k   <= K_W'(CNT_W - 1);
            end
            OP_DIV_STEP: begin
                if (r_rem >= dsh) begin
                    r_rem    <= r_rem - dsh;
                    r_q[r_k] <= 1'b1;
                end
                r_k <= r_k - K_W'(1);
            end
            OP_WIN_WR: begin
                r_g <= clamp_bin(r_q);
            end
            default: ;
        endcase
    end

    // result register
    assign out_space = !r_out_valid || i_out_ready;
    assign rd_ok     = (i_cmd.status == ST_OK);
    assign res_gap   = (rd_ok && r_req == REQ_RDCOL) ? r_win_q : '0;
    assign res_ind   = (rd_ok && r_req == REQ_RDCOL) ? r_ind_q : '0;
    assign res_bin   = (rd_ok && r_req == REQ_RDBIN) ? r_hist_q : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.op == OP_RESULT) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_RESULT) begin
            r_out_data <= {7'b0, (r_col >= eff_cols), r_max, res_bin, res_ind, res_gap,
                           i_cmd.status};
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    always_comb begin
        o_stat.req       = r_req;
        o_stat.load_full = (r_col >= eff_cols);
        o_stat.col_close = close;
        o_stat.fin_ok    = (COL_W'(r_half) <= (eff_cols >> 2)) && (r_col >= eff_cols);
        case (r_req)
            REQ_RDCOL: o_stat.rng_bad = (COL_W'(r_idx) >= eff_cols) || (COL_W'(r_idx) >= r_col);
            REQ_RDBIN: o_stat.rng_bad = (r_idx > COL_AW'(eff_rows));
            default:   o_stat.rng_bad = 1'b0;
        endcase
        o_stat.hclr_last = (r_hidx == HIST_AW'(HIST_DEPTH - 1));
        o_stat.sum_last  = (r_j == $signed({5'b00000, r_half}));
        o_stat.div_last  = (r_k == '0);
        o_stat.win_last  = (COL_W'(r_i) == eff_cols - COL_W'(1));
        o_stat.out_space = out_space;
    end

endmodule

// ===== sv/cgs_controller.sv =====
`timescale 1ns / 1ps

module cgs_controller (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  cgs_pkg::t_dp_stat i_stat,
    output cgs_pkg::t_dp_cmd  o_cmd
);
    import cgs_pkg::*;

    typedef enum logic [4:0] {
        S_RCLR,
        S_IDLE,
        S_DISPATCH,
        S_HINC,
        S_CCLR,
        S_FCLR,
        S_SUM_RD,
        S_SUM_ACC,
        S_DIV_INIT,
        S_DIV_STEP,
        S_WIN_WR,
        S_WIN_INC,
        S_ADD_RD,
        S_ADD_ACC,
        S_SUB_RD,
        S_SUB_ACC,
        S_RESULT
    } t_state;

    t_state  r_state, n_state;
    t_status r_st, n_st;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_RCLR;
            r_st    <= ST_OK;
        end else begin
            r_state <= n_state;
            r_st    <= n_st;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state      = r_state;
        n_st         = r_st;
        o_cmd.op     = OP_NONE;
        o_cmd.status = r_st;
        case (r_state)
            S_RCLR: begin
                o_cmd.op = OP_HCLR;
                if (i_stat.hclr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = OP_CAPTURE;
                    n_state  = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                n_st    = ST_OK;
                n_state = S_RESULT;
                case (i_stat.req)
                    REQ_LOAD: begin
                        if (i_stat.load_full) begin
                            n_st = ST_FULL;
                        end else begin
                            o_cmd.op = OP_LOAD;
                            if (i_stat.col_close) begin
                                n_state = S_HINC;
                            end
                        end
                    end
                    REQ_FIN: begin
                        if (!i_stat.fin_ok) begin
                            n_st = ST_REJECT;
                        end else begin
                            o_cmd.op = OP_FIN_INIT;
                            n_state  = S_FCLR;
                        end
                    end
                    REQ_RDCOL, REQ_RDBIN: begin
                        if (i_stat.rng_bad) begin
                            n_st = ST_RANGE;
                        end else begin
                            o_cmd.op = OP_RD;
                        end
                    end
                    REQ_CLEAR: begin
                        o_cmd.op = OP_CLR;
                        n_state  = S_CCLR;
                    end
                    default: ;
                endcase
            end
            S_HINC: begin
                o_cmd.op = OP_HINC;
                n_state  = S_RESULT;
            end
            S_CCLR: begin
                o_cmd.op = OP_HCLR;
                if (i_stat.hclr_last) begin
                    n_state = S_RESULT;
                end
            end
            S_FCLR: begin
                o_cmd.op = OP_HCLR;
                if (i_stat.hclr_last) begin
                    n_state = S_SUM_RD;
                end
            end
            S_SUM_RD: begin
                o_cmd.op = OP_SUM_RD;
                n_state  = S_SUM_ACC;
            end
            S_SUM_ACC: begin
                o_cmd.op = OP_SUM_ACC;
                n_state  = i_stat.sum_last ? S_DIV_INIT : S_SUM_RD;
            end
            S_DIV_INIT: begin
                o_cmd.op = OP_DIV_INIT;
                n_state  = S_DIV_STEP;
            end
            S_DIV_STEP: begin
                o_cmd.op = OP_DIV_STEP;
                if (i_stat.div_last) begin
                    n_state = S_WIN_WR;
                end
            end
            S_WIN_WR: begin
                o_cmd.op = OP_WIN_WR;
                n_state  = S_WIN_INC;
            end
            S_WIN_INC: begin
                o_cmd.op = OP_HINC;
                n_state  = i_stat.win_last ? S_RESULT : S_ADD_RD;
            end
            S_ADD_RD: begin
                o_cmd.op = OP_ADD_RD;
                n_state  = S_ADD_ACC;
            end
            S_ADD_ACC: begin
                o_cmd.op = OP_ADD_ACC;
                n_state  = S_SUB_RD;
            end
            S_SUB_RD: begin
                o_cmd.op = OP_SUB_RD;
                n_state  = S_SUB_ACC;
            end
            S_SUB_ACC: begin
                o_cmd.op = OP_SUB_ACC;
                n_state  = S_DIV_INIT;
            end
            S_RESULT: begin
                if (i_stat.out_space) begin
                    o_cmd.op = OP_RESULT;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule
